FILE: hdl/bsq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded sorted priority queue package
// Shared types, command codes and size constants.
// ----------------------------------------------------------------------------
package bsq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int RES_W     = 36;
	localparam int CMD_W     = 3;
	localparam int CAP_W     = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUM    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MIN    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_MAX    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd5;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
	localparam logic signed [RES_W-1:0] RES_NONE = '1;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [VAL_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result;
		logic                    status;
	} response_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic                    ins;
		logic                    pop;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

FILE: hdl/bounded_sorted_priority_queue.sv
// A result appears on response with done high in the cycle after start.
// Throughput: one command per cycle; busy stays low, every slot updates in the
// same cycle through the sorted cell chain. Insert gives no result.
// Reset: arst_n clears the count, the running sum and the output strobe, and
// sets capacity to 16; the cell contents stay undefined until written.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
// Bounded sorted priority queue
// Descending chain of value cells with count, running sum and query results.
// ----------------------------------------------------------------------------
module bounded_sorted_priority_queue #(
	parameter int DEPTH = bsq_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  bsq_pkg::request_t            request,
	output logic                         done,
	output bsq_pkg::response_t           response,
	input  logic                         cfg_we,
	input  logic [bsq_pkg::CAP_W-1:0]    cfg_data
);
	import bsq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = VAL_W + 1 + $clog2(DEPTH);
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int SW    = (SUM_W > RES_W) ? SUM_W : RES_W;

	logic [CAP_W-1:0]        cap_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    done_q;
	response_t               resp_q;

	logic signed [VAL_W-1:0] vals [DEPTH];
	logic                    ins_chain [DEPTH];

	logic                    take;
	logic                    empty;
	logic                    full;
	logic [LIM_W-1:0]        limit;
	logic [CNT_W-1:0]        n;
	logic signed [VAL_W-1:0] min_now;
	logic                    beats_min;
	cell_ctl_t               ctl;
	response_t               resp_d;
	logic signed [SW-1:0]    sum_w;

	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign empty = (count_q == '0);

	// Capacity zero acts as one, anything above the depth as the depth.
	always_comb begin
		limit = LIM_W'(cap_q);
		if (limit == '0) begin
			limit = LIM_W'(1);
		end else if (limit > LIM_W'(DEPTH)) begin
			limit = LIM_W'(DEPTH);
		end
	end

	assign full = (LIM_W'(count_q) >= limit);

	// The smallest held value sits in the last occupied cell.
	always_comb begin
		min_now = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (count_q == CNT_W'(i + 1)) begin
				min_now = min_now | vals[i];
			end
		end
	end

	assign beats_min = request.value > min_now;

	// When full the last slot is given up, so insertion runs one slot shorter.
	assign n = full ? (count_q - CNT_W'(1)) : count_q;

	assign ctl.value = request.value;
	assign ctl.ins   = take && (request.cmd == CMD_INSERT) && (!full || beats_min);
	assign ctl.pop   = take && (request.cmd == CMD_POP) && !empty;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                    ins_l;
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;

		if (g == 0) begin : g_first
			assign ins_l  = 1'b0;
			assign left_v = '0;
		end else begin : g_mid
			assign ins_l  = ins_chain[g-1];
			assign left_v = vals[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_v = vals[g];
		end else begin : g_inner
			assign right_v = vals[g+1];
		end

		bsq_cell #(
			.DEPTH (DEPTH),
			.IDX   (g)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.n         (n),
			.ins_left  (ins_l),
			.left_val  (left_v),
			.right_val (right_v),
			.ins_out   (ins_chain[g]),
			.value_out (vals[g])
		);
	end

	assign sum_w = SW'(sum_q);

	always_comb begin
		resp_d.result = '0;
		resp_d.status = STATUS_OK;
		if (request.cmd == CMD_COUNT) begin
			resp_d.result = RES_W'(count_q);
		end else if (empty) begin
			resp_d.result = RES_NONE;
			resp_d.status = STATUS_EMPTY;
		end else begin
			case (request.cmd)
				CMD_POP, CMD_MAX: begin
					resp_d.result = RES_W'(vals[0]);
				end
				CMD_MIN: begin
					resp_d.result = RES_W'(min_now);
				end
				CMD_SUM: begin
					if (sum_w > SW'(RES_MAX)) begin
						resp_d.result = RES_MAX;
					end else if (sum_w < SW'(RES_MIN)) begin
						resp_d.result = RES_MIN;
					end else begin
						resp_d.result = RES_W'(sum_w);
					end
				end
				default: begin
					resp_d.result = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			sum_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			done_q <= take && (request.cmd != CMD_INSERT);
			if (ctl.ins) begin
				if (full) begin
					sum_q <= sum_q + SUM_W'(request.value) - SUM_W'(min_now);
				end else begin
					sum_q   <= sum_q + SUM_W'(request.value);
					count_q <= count_q + CNT_W'(1);
				end
			end else if (ctl.pop) begin
				sum_q   <= sum_q - SUM_W'(vals[0]);
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			resp_q <= resp_d;
		end
	end

	assign done     = done_q;
	assign response = resp_q;

endmodule

FILE: hdl/bsq_cell.sv
// ----------------------------------------------------------------------------
// Bounded sorted priority queue cell
// One slot of the sorted chain; shifts toward its neighbors on insert and pop.
// ----------------------------------------------------------------------------
module bsq_cell #(
	parameter int DEPTH = bsq_pkg::DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                                    clk,
	input  bsq_pkg::cell_ctl_t                      ctl,
	input  logic [CNT_W-1:0]                        n,
	input  logic                                    ins_left,
	input  logic signed [bsq_pkg::VAL_W-1:0]        left_val,
	input  logic signed [bsq_pkg::VAL_W-1:0]        right_val,
	output logic                                    ins_out,
	output logic signed [bsq_pkg::VAL_W-1:0]        value_out
);
	import bsq_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic signed [VAL_W-1:0] entry_q;

	// This slot and every one after it, up to slot n, move on an insert.
	assign ins_out = ctl.ins && (((n > MY_IDX) && (ctl.value > entry_q)) || (n == MY_IDX));
	assign value_out = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			entry_q <= right_val;
		end else if (ins_left) begin
			entry_q <= left_val;
		end else if (ins_out) begin
			entry_q <= ctl.value;
		end
	end

endmodule
